@@ src/fra_pkg.sv @@
`timescale 1ns / 1ps

package fra_pkg;

  // Operation codes carried in the action field.
  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } act_e;

  // Commands from the controller to the datapath, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_MUL0,
    CMD_MUL1,
    CMD_MUL2,
    CMD_COMB,
    CMD_GINIT,
    CMD_GSTEP,
    CMD_DINIT,
    CMD_DSTEP,
    CMD_PUBLISH
  } cmd_e;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic den_zero;
    logic gcd_done;
  } status_t;

endpackage

@@ src/fra_in_if.sv @@
`timescale 1ns / 1ps

interface fra_in_if #(
  parameter int unsigned OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic signed [OPERAND_WIDTH-1:0] num_a;
  logic signed [OPERAND_WIDTH-1:0] den_a;
  logic signed [OPERAND_WIDTH-1:0] num_b;
  logic signed [OPERAND_WIDTH-1:0] den_b;

  modport source (output valid, action, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, action, num_a, den_a, num_b, den_b, output ready);
endinterface

@@ src/fra_out_if.sv @@
`timescale 1ns / 1ps

interface fra_out_if #(
  parameter int unsigned OPERAND_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic signed [2*OPERAND_WIDTH:0]   res_num;
  logic [2*OPERAND_WIDTH-2:0]        res_den;
  logic                              whole;
  logic                              bad_den;

  modport source (output valid, res_num, res_den, whole, bad_den, input ready);
  modport sink   (input valid, res_num, res_den, whole, bad_den, output ready);
endinterface

@@ src/fraction_arith_reduce_top.sv @@
`timescale 1ns / 1ps

// Rational arithmetic unit with reduction to lowest terms.
// in_if carries an operation (add, subtract, multiply, divide) and two signed
// fractions; out_if returns the reduced numerator with the sign, the
// non-negative reduced denominator, a flag for a denominator of one and a
// flag for a zero raw denominator. A transfer happens at each edge at which
// valid and ready are both high; every input gives exactly one result.
// One item is in work at a time. After the input transfer the block forms
// three products on one shared multiplier, forms and checks the raw terms,
// runs a binary GCD (one halving or subtraction per step, the last step
// starting the divider), then a restoring divider that divides numerator
// and denominator in parallel, and finally loads the output register; the
// next input is taken once that load is done. A zero denominator skips the
// GCD and divider and goes straight to the output register.
// The result sits in an output register, so the next input is taken while a
// finished result still waits for the receiver. When the receiver stalls, a
// second result waits in the datapath and the input is held off until the
// register frees. Reset clears the controller; no result is pending after it.
module fraction_arith_reduce_top #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fra_in_if.sink    in_if,
  fra_out_if.source out_if
);

  fra_pkg::cmd_e    cmd;
  fra_pkg::status_t status;

  // Controller: sequences the datapath and owns both handshakes.
  fra_ctrl #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: multiplier, GCD engine, dividers and the result register.
  fra_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .action_i  (in_if.action),
    .num_a_i   (in_if.num_a),
    .den_a_i   (in_if.den_a),
    .num_b_i   (in_if.num_b),
    .den_b_i   (in_if.den_b),
    .res_num_o (out_if.res_num),
    .res_den_o (out_if.res_den),
    .whole_o   (out_if.whole),
    .bad_den_o (out_if.bad_den)
  );

endmodule

@@ src/fra_ctrl.sv @@
`timescale 1ns / 1ps

module fra_ctrl #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fra_pkg::status_t  status_i,
  output fra_pkg::cmd_e     cmd_o
);

  localparam int unsigned PW = 2 * OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(PW);
  localparam logic [CW-1:0] CNT_LAST = CW'(PW - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_CHECK,
    S_GCD,
    S_DIV,
    S_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;
  logic          slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = fra_pkg::CMD_NONE;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = fra_pkg::CMD_LOAD;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o   = fra_pkg::CMD_MUL0;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o   = fra_pkg::CMD_MUL1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o   = fra_pkg::CMD_MUL2;
        state_d = S_COMB;
      end
      S_COMB: begin
        cmd_o   = fra_pkg::CMD_COMB;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o   = fra_pkg::CMD_GINIT;
        state_d = status_i.den_zero ? S_DONE : S_GCD;
      end
      S_GCD: begin
        if (status_i.gcd_done) begin
          cmd_o   = fra_pkg::CMD_DINIT;
          state_d = S_DIV;
        end else begin
          cmd_o = fra_pkg::CMD_GSTEP;
        end
      end
      S_DIV: begin
        cmd_o = fra_pkg::CMD_DSTEP;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o       = fra_pkg::CMD_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == fra_pkg::CMD_PUBLISH) |-> slot_free)
    else $error("result published over a pending one");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DIV) |-> (cnt_q == '0))
    else $error("division counter not cleared outside division");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL0))
    else $error("accepted item did not start the multiply sequence");
`endif

endmodule

@@ src/fra_dp.sv @@
`timescale 1ns / 1ps

module fra_dp #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fra_pkg::cmd_e                     cmd_i,
  output fra_pkg::status_t                  status_o,
  input  logic [1:0]                        action_i,
  input  logic signed [OPERAND_WIDTH-1:0]   num_a_i,
  input  logic signed [OPERAND_WIDTH-1:0]   den_a_i,
  input  logic signed [OPERAND_WIDTH-1:0]   num_b_i,
  input  logic signed [OPERAND_WIDTH-1:0]   den_b_i,
  output logic signed [2*OPERAND_WIDTH:0]   res_num_o,
  output logic [2*OPERAND_WIDTH-2:0]        res_den_o,
  output logic                              whole_o,
  output logic                              bad_den_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned KW = $clog2(PW);

  // Operand registers.
  fra_pkg::act_e          act_q;
  logic signed [W-1:0]    a_q, da_q, b_q, db_q;

  // Products and raw terms.
  logic signed [PW-1:0]   p1_q, p2_q, den_q;
  logic signed [PW:0]     num_q;

  // GCD and division state.
  logic [PW-1:0]          u_q, v_q, g_q;
  logic [PW-1:0]          qn_q, qd_q;
  logic [PW-1:0]          rn_q, rd_q;
  logic [KW-1:0]          k_q;
  logic                   strip_q;
  logic                   neg_q;

  // Result register.
  logic signed [PW:0]     res_num_q;
  logic [PW-2:0]          res_den_q;
  logic                   whole_q;
  logic                   bad_q;

  logic signed [W-1:0]    mul_x, mul_y;
  logic signed [PW-1:0]   prod;
  logic signed [PW:0]     p1_ext, p2_ext;
  logic [PW:0]            num_abs, den_abs;
  logic [PW:0]            rn_sh, rd_sh, g_ext;
  logic                   qn_bit, qd_bit;
  logic                   bad;
  logic [PW:0]            q_ext;

  // One shared signed multiplier, steered by the current command.
  always_comb begin
    unique case (cmd_i)
      fra_pkg::CMD_MUL0: begin
        mul_x = a_q;
        mul_y = (act_q == fra_pkg::ACT_MUL) ? b_q : db_q;
      end
      fra_pkg::CMD_MUL1: begin
        mul_x = b_q;
        mul_y = da_q;
      end
      default: begin
        mul_x = da_q;
        mul_y = (act_q == fra_pkg::ACT_DIV) ? b_q : db_q;
      end
    endcase
  end

  assign prod   = mul_x * mul_y;
  assign p1_ext = {p1_q[PW-1], p1_q};
  assign p2_ext = {p2_q[PW-1], p2_q};

  assign num_abs = num_q[PW] ? (-num_q) : num_q;
  assign den_abs = den_q[PW-1] ? (-{den_q[PW-1], den_q}) : {den_q[PW-1], den_q};

  // Restoring division step, numerator and denominator side by side.
  assign g_ext  = {1'b0, g_q};
  assign rn_sh  = {rn_q, qn_q[PW-1]};
  assign rd_sh  = {rd_q, qd_q[PW-1]};
  assign qn_bit = (rn_sh >= g_ext);
  assign qd_bit = (rd_sh >= g_ext);

  assign status_o.den_zero = (den_q == '0);
  assign status_o.gcd_done = (u_q == '0);

  assign bad   = (den_q == '0);
  assign q_ext = {1'b0, qn_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
      k_q     <= '0;
    end else begin
      unique case (cmd_i)
        fra_pkg::CMD_GINIT: begin
          strip_q <= 1'b1;
          k_q     <= '0;
        end
        fra_pkg::CMD_GSTEP: begin
          if (strip_q) begin
            if (!u_q[0] && !v_q[0]) begin
              k_q <= k_q + 1'b1;
            end else begin
              strip_q <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      fra_pkg::CMD_LOAD: begin
        act_q <= fra_pkg::act_e'(action_i);
        a_q   <= num_a_i;
        da_q  <= den_a_i;
        b_q   <= num_b_i;
        db_q  <= den_b_i;
      end
      fra_pkg::CMD_MUL0: begin
        p1_q <= prod;
      end
      fra_pkg::CMD_MUL1: begin
        p2_q <= prod;
      end
      fra_pkg::CMD_MUL2: begin
        den_q <= prod;
      end
      fra_pkg::CMD_COMB: begin
        unique case (act_q)
          fra_pkg::ACT_ADD: num_q <= p1_ext + p2_ext;
          fra_pkg::ACT_SUB: num_q <= p1_ext - p2_ext;
          default:          num_q <= p1_ext;
        endcase
      end
      fra_pkg::CMD_GINIT: begin
        u_q   <= num_abs[PW-1:0];
        v_q   <= den_abs[PW-1:0];
        qn_q  <= num_abs[PW-1:0];
        qd_q  <= den_abs[PW-1:0];
        neg_q <= num_q[PW] ^ den_q[PW-1];
      end
      fra_pkg::CMD_GSTEP: begin
        // Binary GCD: strip common factors of two first, then reduce the
        // odd parts by halving and subtracting until u reaches zero.
        priority if (strip_q) begin
          if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
          end
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      fra_pkg::CMD_DINIT: begin
        g_q  <= v_q << k_q;
        rn_q <= '0;
        rd_q <= '0;
      end
      fra_pkg::CMD_DSTEP: begin
        rn_q <= qn_bit ? PW'(rn_sh - g_ext) : rn_sh[PW-1:0];
        rd_q <= qd_bit ? PW'(rd_sh - g_ext) : rd_sh[PW-1:0];
        qn_q <= {qn_q[PW-2:0], qn_bit};
        qd_q <= {qd_q[PW-2:0], qd_bit};
      end
      fra_pkg::CMD_PUBLISH: begin
        bad_q <= bad;
        if (bad) begin
          res_num_q <= '0;
          res_den_q <= '0;
          whole_q   <= 1'b0;
        end else begin
          res_num_q <= neg_q ? (-q_ext) : q_ext;
          res_den_q <= qd_q[PW-2:0];
          whole_q   <= (qd_q == PW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign whole_o   = whole_q;
  assign bad_den_o = bad_q;

`ifndef SYNTHESIS
  a_gcd_v_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == fra_pkg::CMD_GSTEP) |-> (v_q != '0))
    else $error("GCD step with zero second operand");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == fra_pkg::CMD_DSTEP) |-> (g_q != '0))
    else $error("division step with zero divisor");

  a_reduced_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == fra_pkg::CMD_PUBLISH && den_q != '0) |=> (res_den_q != '0))
    else $error("reduced denominator is zero for a valid result");
`endif

endmodule

@@ test/tb_fraction_arith_reduce_top.sv @@
`timescale 1ns / 1ps

module tb_fraction_arith_reduce_top;

  localparam int unsigned OW             = 16;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          TAIL_CYCLES    = 200;

  localparam logic signed [OW-1:0] OP_MIN = 16'sh8000;
  localparam logic signed [OW-1:0] OP_MAX = 16'sh7FFF;

  typedef struct packed {
    logic signed [2*OW:0] res_num;
    logic [2*OW-2:0]      res_den;
    logic                 whole;
    logic                 bad_den;
  } frac_res_t;

  logic clk;
  logic rst_n;

  fra_in_if  #(.OPERAND_WIDTH(OW)) in_ch ();
  fra_out_if #(.OPERAND_WIDTH(OW)) out_ch ();

  fraction_arith_reduce_top #(.OPERAND_WIDTH(OW)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  frac_res_t pending_results[$];
  frac_res_t want;
  int        error_count   = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left     = 0;
  int        next_gap      = 0;
  bit        bus_parked    = 1'b1;
  int        quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reduced fraction for one operation, sign moved onto the numerator.
  function automatic frac_res_t predict_reduced_fraction(
    input fra_pkg::act_e op, input logic signed [OW-1:0] a,
    input logic signed [OW-1:0] da,
    input logic signed [OW-1:0] b, input logic signed [OW-1:0] db);
    longint          sa, sda, sb, sdb, num, den;
    longint unsigned mn, md, x, y, t, rn, rd;
    frac_res_t       r;
    sa  = a;
    sda = da;
    sb  = b;
    sdb = db;
    case (op)
      fra_pkg::ACT_ADD: begin
        num = sa * sdb + sb * sda;
        den = sda * sdb;
      end
      fra_pkg::ACT_SUB: begin
        num = sa * sdb - sb * sda;
        den = sda * sdb;
      end
      fra_pkg::ACT_MUL: begin
        num = sa * sb;
        den = sda * sdb;
      end
      default: begin
        num = sa * sdb;
        den = sda * sb;
      end
    endcase
    r = '0;
    if (den == 0) begin
      r.bad_den = 1'b1;
      return r;
    end
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    x = mn;
    y = md;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    rn = mn / x;
    rd = md / x;
    if ((num < 0) != (den < 0)) rn = -rn;
    r.res_num = rn[2*OW:0];
    r.res_den = rd[2*OW-2:0];
    r.whole   = (rd == 1);
    return r;
  endfunction

  function automatic int draw_gap();
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 400) gap++;
    return gap;
  endfunction

  // Operands mix full-range values, small values, extremes and values with
  // large power-of-two factors so that the reduction has real work to do.
  function automatic logic signed [OW-1:0] rand_operand();
    logic signed [OW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = OW'($urandom());
      4, 5:       v = OW'(int'($urandom_range(40)) - 20);
      6: begin
        case ($urandom_range(4))
          0:       v = OP_MIN;
          1:       v = OP_MAX;
          2:       v = '1;
          3:       v = '0;
          default: v = OW'(1);
        endcase
      end
      default:    v = OW'((int'($urandom_range(30)) - 15) * (1 << $urandom_range(10)));
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Offers one item, waits for its transfer and queues the prediction. The
  // valid line stays high only when the next item follows back to back.
  task automatic send_frac(input fra_pkg::act_e op, input logic signed [OW-1:0] a,
                           input logic signed [OW-1:0] da, input logic signed [OW-1:0] b,
                           input logic signed [OW-1:0] db, input bit last);
    if (bus_parked) @(posedge clk);
    repeat (next_gap) @(posedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.action <= op;
    in_ch.num_a  <= a;
    in_ch.den_a  <= da;
    in_ch.num_b  <= b;
    in_ch.den_b  <= db;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_results.push_back(predict_reduced_fraction(op, a, da, b, db));
    next_gap = last ? 0 : draw_gap();
    if (last || next_gap != 0) in_ch.valid <= 1'b0;
    bus_parked = last;
  endtask

  task automatic send_random_frac(input bit last);
    send_frac(fra_pkg::act_e'($urandom_range(3)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand(), last);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    next_gap       = 0;
    for (int i = 0; i < count; i++) send_random_frac(i == count - 1);
    wait_drained();
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Plain cases of each operation.
    send_frac(fra_pkg::ACT_ADD, 1, 2, 1, 3, 1'b0);
    send_frac(fra_pkg::ACT_SUB, 1, 2, 1, 2, 1'b0);
    send_frac(fra_pkg::ACT_MUL, 2, 3, 3, 4, 1'b0);
    send_frac(fra_pkg::ACT_DIV, 2, 3, 4, 9, 1'b0);
    // Zero raw denominator, for every operation.
    send_frac(fra_pkg::ACT_ADD, 1, 0, 1, 2, 1'b0);
    send_frac(fra_pkg::ACT_SUB, 3, 5, 1, 0, 1'b0);
    send_frac(fra_pkg::ACT_MUL, 0, 0, 0, 0, 1'b0);
    send_frac(fra_pkg::ACT_DIV, 1, 2, 0, 3, 1'b0);
    // Zero numerator, also with a negative denominator.
    send_frac(fra_pkg::ACT_MUL, 0, -5, 3, 7, 1'b0);
    send_frac(fra_pkg::ACT_ADD, 0, OP_MIN, 0, OP_MAX, 1'b0);
    // Negative denominators move the sign onto the numerator.
    send_frac(fra_pkg::ACT_ADD, 1, -2, 1, -3, 1'b0);
    send_frac(fra_pkg::ACT_MUL, 1, -2, 1, 3, 1'b0);
    send_frac(fra_pkg::ACT_DIV, 1, 2, -1, 3, 1'b0);
    send_frac(fra_pkg::ACT_MUL, -3, -4, 2, 3, 1'b0);
    // Whole results.
    send_frac(fra_pkg::ACT_DIV, 6, 1, 3, 1, 1'b0);
    send_frac(fra_pkg::ACT_MUL, -4, 2, 3, 1, 1'b0);
    // Extreme operands; the first gives a raw numerator of two to the 31st.
    send_frac(fra_pkg::ACT_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1'b0);
    send_frac(fra_pkg::ACT_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX, 1'b0);
    send_frac(fra_pkg::ACT_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN, 1'b0);
    send_frac(fra_pkg::ACT_MUL, OP_MIN, 1, OP_MIN, 1, 1'b0);
    send_frac(fra_pkg::ACT_DIV, OP_MIN, 1, 1, OP_MIN, 1'b0);
    send_frac(fra_pkg::ACT_DIV, OP_MAX, OP_MIN, OP_MIN, OP_MAX, 1'b0);
    send_frac(fra_pkg::ACT_SUB, -1, -1, OP_MAX, -1, 1'b0);
    send_frac(fra_pkg::ACT_MUL, OP_MAX, OP_MIN, -1, OP_MAX, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    run_random_phase(320, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_phase(260, 88, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_phase(260, 0, 88);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(512, 23, 23);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the output register and the controller fill and the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    next_gap       = 0;
    @(negedge clk);
    hold_left = 1500;
    for (int i = 0; i < 24; i++) send_random_frac(i == 23);
    wait_drained();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= fra_pkg::ACT_ADD;
    in_ch.num_a   <= '0;
    in_ch.den_a   <= '0;
    in_ch.num_b   <= '0;
    in_ch.den_b   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_backpressure();
    test_random_both_idle();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("results still outstanding at end");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, plus a counted hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result num %0d den %0d",
                                  out_ch.res_num, out_ch.res_den));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.res_num !== want.res_num)
          report_mismatch($sformatf("res_num got %0d expected %0d",
                                    out_ch.res_num, want.res_num));
        if (out_ch.res_den !== want.res_den)
          report_mismatch($sformatf("res_den got %0d expected %0d",
                                    out_ch.res_den, want.res_den));
        if (out_ch.whole !== want.whole)
          report_mismatch($sformatf("whole got %b expected %b", out_ch.whole, want.whole));
        if (out_ch.bad_den !== want.bad_den)
          report_mismatch($sformatf("bad_den got %b expected %b",
                                    out_ch.bad_den, want.bad_den));
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
